[rtl/djd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// djd_pkg
// Constants and month tables for Julian day number encoding and decoding.
// ----------------------------------------------------------------------------
package djd_pkg;

	// Commands carried in the input user field.
	localparam logic CMD_DIFF = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	// Field widths.
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OFF_W   = 24;
	localparam int DIFF_W  = 23;
	localparam int JD_W    = 24;
	localparam int Z_W     = 23;

	// Packed stream widths, padded to whole bytes.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 48;

	// Decodable day number range and start of the Gregorian calendar.
	localparam logic signed [25:0] JD_MIN     = 26'sd1721424;
	localparam logic signed [25:0] JD_MAX     = 26'sd5373484;
	localparam logic signed [25:0] GREG_START = 26'sd2299161;

	// Saturation limits of the difference field.
	localparam logic signed [24:0] DIFF_MAX = 25'sd4194303;
	localparam logic signed [24:0] DIFF_MIN = -25'sd4194304;

	// Reciprocal multipliers, each exact over the value range it sees.
	// 100 with a shift of 19, 146097 with a shift of 42, 7305 with a shift
	// of 40, and 30.6001 (as 306001 / 10000) with a shift of 32.
	localparam logic [12:0] RCP_CEN  = 13'd5243;
	localparam logic [24:0] RCP_GREG = 25'd30103606;
	localparam logic [27:0] RCP_YEAR = 28'd150514939;
	localparam logic [27:0] RCP_MON  = 28'd140357950;

	// Whole days covered by k months of 30.6001 days, rounded down.
	function automatic logic [8:0] month_days(input logic [4:0] k);
		logic [8:0] r;
		unique case (k)
			5'd0:    r = 9'd0;
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd153;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd306;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			5'd13:   r = 9'd397;
			5'd14:   r = 9'd428;
			5'd15:   r = 9'd459;
			5'd16:   r = 9'd489;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/date_julian_day_arith.sv]
`default_nettype none
// Throughput: one transaction per cycle while the output is not held; every stage holds one item.
// The whole pipeline holds while a finished result waits at the output.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// date_julian_day_arith
// Julian day number date arithmetic: difference of two dates, or a date plus
// a signed offset decoded back into year, month and day.
// ----------------------------------------------------------------------------
module date_julian_day_arith (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// Fields from bit 0 up: first_year, first_month, first_day, second_year,
	// second_month, second_day, day_offset, zero pad.
	input  wire logic [71:0] s_tdata,
	// Fields from bit 0 up: cmd.
	input  wire logic [0:0]  s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// Fields from bit 0 up: day_difference, result_year, result_month,
	// result_day, zero pad.
	output      logic [47:0] m_tdata,
	// Fields from bit 0 up: out_of_range.
	output      logic [0:0]  m_tuser
);

	// Stage map:
	//   s1  month adjust, year products for both dates
	//   s2  day numbers of both dates
	//   s3  difference with saturation, offset sum and range check
	//   s4  century estimate product for the Gregorian correction
	//   s5  corrected day base and year numerator
	//   s6  year quotient product
	//   s7  year count and its day product
	//   s8  day of year and month quotient product
	//   s9  month, day and year of the sum; this is the output register
	// All stages advance together whenever the output register is free or
	// is being emptied in the same cycle.

	// Valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic en;
	assign en       = !v_s9 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Input fields.
	logic        in_cmd;
	logic [13:0] y1_in, y2_in;
	logic [3:0]  m1_in, m2_in;
	logic [4:0]  d1_in, d2_in;
	logic [23:0] off_in;

	assign in_cmd = s_tuser[0];
	assign y1_in  = s_tdata[13:0];
	assign m1_in  = s_tdata[17:14];
	assign d1_in  = s_tdata[22:18];
	assign y2_in  = s_tdata[36:23];
	assign m2_in  = s_tdata[40:37];
	assign d2_in  = s_tdata[45:41];
	assign off_in = s_tdata[69:46];

	// ---- Stage 1 ----
	// January and February count as months 13 and 14 of the year before.
	// The century value of year -1 is taken as zero.
	logic        dec1, dec2;
	logic [14:0] yb1, yb2;
	logic [13:0] yc1, yc2;
	logic [4:0]  mi1, mi2;

	assign dec1 = (m1_in <= 4'd2);
	assign dec2 = (m2_in <= 4'd2);
	assign yb1  = {1'b0, y1_in} + 15'd4716 - {14'd0, dec1};
	assign yb2  = {1'b0, y2_in} + 15'd4716 - {14'd0, dec2};
	assign yc1  = (dec1 && y1_in == 14'd0) ? 14'd0 : y1_in - {13'd0, dec1};
	assign yc2  = (dec2 && y2_in == 14'd0) ? 14'd0 : y2_in - {13'd0, dec2};
	assign mi1  = (dec1 ? {1'b0, m1_in} + 5'd12 : {1'b0, m1_in}) + 5'd1;
	assign mi2  = (dec2 ? {1'b0, m2_in} + 5'd12 : {1'b0, m2_in}) + 5'd1;

	logic        cmd_s1;
	logic [23:0] off_s1;
	logic [24:0] cp1_s1, cp2_s1;
	logic [26:0] cen1_s1, cen2_s1;
	logic [9:0]  md1_s1, md2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= in_cmd;
			off_s1  <= off_in;
			cp1_s1  <= 25'(yb1) * 25'd1461;
			cp2_s1  <= 25'(yb2) * 25'd1461;
			cen1_s1 <= 27'(yc1) * 27'(djd_pkg::RCP_CEN);
			cen2_s1 <= 27'(yc2) * 27'(djd_pkg::RCP_CEN);
			md1_s1  <= 10'(djd_pkg::month_days(mi1)) + 10'(d1_in);
			md2_s1  <= 10'(djd_pkg::month_days(mi2)) + 10'(d2_in);
		end
	end

	// ---- Stage 2 ----
	// Day number = year days + month days + day + Gregorian correction - 1524.
	// The sum is always positive, so modular arithmetic at this width is exact.
	logic [7:0]  cen1, cen2;
	logic [23:0] jd1_c, jd2_c;

	assign cen1  = cen1_s1[26:19];
	assign cen2  = cen2_s1[26:19];
	assign jd1_c = 24'(cp1_s1 >> 2) + 24'(md1_s1) + 24'(cen1 >> 2) + 24'd2
		- 24'(cen1) - 24'd1524;
	assign jd2_c = 24'(cp2_s1 >> 2) + 24'(md2_s1) + 24'(cen2 >> 2) + 24'd2
		- 24'(cen2) - 24'd1524;

	logic        cmd_s2;
	logic [23:0] off_s2;
	logic [23:0] jd1_s2, jd2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			off_s2 <= off_s1;
			jd1_s2 <= jd1_c;
			jd2_s2 <= jd2_c;
		end
	end

	// ---- Stage 3 ----
	logic signed [24:0] diff_c;
	logic signed [25:0] sum_c;
	logic [22:0]        diff_sat;
	logic               oor_c;

	assign diff_c = $signed({1'b0, jd2_s2}) - $signed({1'b0, jd1_s2});
	assign sum_c  = $signed({2'b00, jd1_s2}) + $signed({{2{off_s2[23]}}, off_s2});
	assign oor_c  = (sum_c < djd_pkg::JD_MIN) || (sum_c > djd_pkg::JD_MAX);

	always_comb begin
		priority if (diff_c > djd_pkg::DIFF_MAX) begin
			diff_sat = djd_pkg::DIFF_MAX[22:0];
		end else if (diff_c < djd_pkg::DIFF_MIN) begin
			diff_sat = djd_pkg::DIFF_MIN[22:0];
		end else begin
			diff_sat = diff_c[22:0];
		end
	end

	logic        cmd_s3;
	logic [22:0] diff_s3;
	logic        oor_s3;
	logic        greg_s3;
	logic [22:0] z_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3  <= cmd_s2;
			diff_s3 <= (cmd_s2 == djd_pkg::CMD_DIFF) ? diff_sat : 23'd0;
			oor_s3  <= (cmd_s2 == djd_pkg::CMD_ADD) && oor_c;
			greg_s3 <= (sum_c >= djd_pkg::GREG_START);
			z_s3    <= sum_c[22:0];
		end
	end

	// ---- Stage 4 ----
	// Century estimate x = (4z - 7468865) / 146097, used only in the
	// Gregorian range where the numerator is positive.
	logic [23:0] gn;
	assign gn = {1'b0, z_s3} * 24'd4 - 24'd7468865;

	logic        cmd_s4, oor_s4, greg_s4;
	logic [22:0] diff_s4, z_s4;
	logic [48:0] xp_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4  <= cmd_s3;
			oor_s4  <= oor_s3;
			greg_s4 <= greg_s3;
			diff_s4 <= diff_s3;
			z_s4    <= z_s3;
			xp_s4   <= 49'(gn) * 49'(djd_pkg::RCP_GREG);
		end
	end

	// ---- Stage 5 ----
	logic [6:0]  xq;
	logic [7:0]  gadj;
	logic [22:0] b_c;

	assign xq   = xp_s4[48:42];
	assign gadj = greg_s4 ? 8'd1 + 8'(xq) - 8'(xq >> 2) : 8'd0;
	assign b_c  = z_s4 + 23'(gadj) + 23'd1524;

	logic        cmd_s5, oor_s5;
	logic [22:0] diff_s5, b_s5;
	logic [26:0] yn_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s5  <= cmd_s4;
			oor_s5  <= oor_s4;
			diff_s5 <= diff_s4;
			b_s5    <= b_c;
			yn_s5   <= 27'(b_c) * 27'd20 - 27'd2442;
		end
	end

	// ---- Stage 6 ----
	// Year count c = (20b - 2442) / 7305.
	logic        cmd_s6, oor_s6;
	logic [22:0] diff_s6, b_s6;
	logic [54:0] cpq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s6  <= cmd_s5;
			oor_s6  <= oor_s5;
			diff_s6 <= diff_s5;
			b_s6    <= b_s5;
			cpq_s6  <= 55'(yn_s5) * 55'(djd_pkg::RCP_YEAR);
		end
	end

	// ---- Stage 7 ----
	logic [13:0] cy;
	assign cy = cpq_s6[53:40];

	logic        cmd_s7, oor_s7;
	logic [22:0] diff_s7, b_s7;
	logic [13:0] c_s7;
	logic [24:0] dp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s7  <= cmd_s6;
			oor_s7  <= oor_s6;
			diff_s7 <= diff_s6;
			b_s7    <= b_s6;
			c_s7    <= cy;
			dp_s7   <= 25'(cy) * 25'd1461;
		end
	end

	// ---- Stage 8 ----
	// Days into the March-based year, then the month count e.
	logic [22:0] bd_full;
	logic [9:0]  bd_c;

	assign bd_full = b_s7 - 23'(dp_s7 >> 2);
	assign bd_c    = bd_full[9:0];

	logic        cmd_s8, oor_s8;
	logic [22:0] diff_s8;
	logic [13:0] c_s8;
	logic [9:0]  bd_s8;
	logic [37:0] ep_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s8  <= cmd_s7;
			oor_s8  <= oor_s7;
			diff_s8 <= diff_s7;
			c_s8    <= c_s7;
			bd_s8   <= bd_c;
			ep_s8   <= 38'(bd_c) * 38'(djd_pkg::RCP_MON);
		end
	end

	// ---- Stage 9 ----
	// Months 14 and 15 of the count are January and February of the next year.
	logic [4:0]  ec;
	logic [9:0]  dd_full;
	logic [3:0]  mon_c;
	logic [13:0] yy_c;
	logic        show_date;

	assign ec        = ep_s8[36:32];
	assign dd_full   = bd_s8 - 10'(djd_pkg::month_days(ec));
	assign mon_c     = (ec < 5'd14) ? 4'(ec - 5'd1) : 4'(ec - 5'd13);
	assign yy_c      = (mon_c > 4'd2) ? c_s8 - 14'd4716 : c_s8 - 14'd4715;
	assign show_date = (cmd_s8 == djd_pkg::CMD_ADD) && !oor_s8;

	logic [22:0] diff_s9;
	logic [13:0] ry_s9;
	logic [3:0]  rm_s9;
	logic [4:0]  rd_s9;
	logic        oor_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s9 <= diff_s8;
			ry_s9   <= show_date ? yy_c : 14'd0;
			rm_s9   <= show_date ? mon_c : 4'd0;
			rd_s9   <= show_date ? dd_full[4:0] : 5'd0;
			oor_s9  <= oor_s8;
		end
	end

	// Output transaction.
	assign m_tvalid = v_s9;
	assign m_tdata  = {2'b00, rd_s9, rm_s9, ry_s9, diff_s9};
	assign m_tuser  = oor_s9;

endmodule
`default_nettype wire
